/* design/imps_pkg.sv */
package imps_pkg;

  localparam int unsigned START_OFFSET = 8;

  localparam int unsigned READING_W = 16;
  localparam int unsigned THRESH_W  = 16;
  localparam int unsigned LIMIT_W   = 9;
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned MOVE_W    = 7;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned ROUND_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 2'd2;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_READING = 1'b1;

  function automatic logic signed [POS_W-1:0] round_offset(input logic [ROUND_W-1:0] k);
    logic [31:0] off;
    off = 32'(START_OFFSET) >> k;
    return POS_W'(off);
  endfunction

  function automatic logic round_live(input logic [ROUND_W-1:0] k);
    logic [31:0] twice;
    twice = (32'(START_OFFSET) << 1) >> k;
    return twice != 32'd0;
  endfunction

endpackage

/* design/index_mark_peak_seek.sv */
// A result word is registered into the output register as its input word is accepted.
// Throughput: one input word per cycle; a word stalls only while the output register
//   holds an untaken result and m_axis_tready is low.
// Reset (rst_ni low, asynchronous): idle phase, search state cleared, output empty,
//   registers back to threshold 32, coarse limit 360, coarse step 4.
module index_mark_peak_seek (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [imps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [imps_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [imps_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [15:0] sensor_reading
  input  logic                                s_axis_tuser,  // [0] op
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [imps_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // [6:0] move_steps, [7] zero
  output logic                                m_axis_tlast   // calibrated
);
  import imps_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_COARSE = 2'd1,
    PH_REFINE = 2'd2
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [LIMIT_W-1:0]        count_q, count_d;
  logic signed [POS_W-1:0]   cur_q, cur_d;
  logic signed [POS_W-1:0]   best_pos_q, best_pos_d;
  logic [READING_W-1:0]      best_rd_q, best_rd_d;
  logic [ROUND_W-1:0]        round_q, round_d;
  logic                      minus_q, minus_d;

  logic [THRESH_W-1:0]       thresh_q;
  logic [LIMIT_W-1:0]        limit_q;
  logic [STEP_W-1:0]         step_q;

  logic                      out_valid_q;
  logic [MOVE_W-1:0]         out_move_q;
  logic                      out_cal_q;

  logic                      s_acc;
  logic                      has_res;
  logic [MOVE_W-1:0]         move_d;
  logic                      cal_d;
  logic                      op;
  logic [READING_W-1:0]      reading;
  logic                      abort_now;
  logic signed [POS_W-1:0]   best_new;
  logic signed [POS_W-1:0]   target;
  logic                      use_target;
  logic [ROUND_W-1:0]        round_nx;

  assign op            = s_axis_tuser;
  assign reading       = s_axis_tdata[READING_W-1:0];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_move_q};
  assign m_axis_tlast  = out_cal_q;

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    cur_d      = cur_q;
    best_pos_d = best_pos_q;
    best_rd_d  = best_rd_q;
    round_d    = round_q;
    minus_d    = minus_q;
    has_res    = 1'b0;
    move_d     = {1'b0, step_q};
    cal_d      = 1'b0;
    target     = '0;
    use_target = 1'b0;
    abort_now  = count_q >= limit_q;
    best_new   = best_pos_q;
    round_nx   = round_q + ROUND_W'(1);

    if (op == OP_START) begin
      phase_d = PH_COARSE;
      count_d = '0;
      has_res = 1'b1;
    end else begin
      unique case (phase_q)
        PH_COARSE: begin
          has_res = 1'b1;
          if (!abort_now) begin
            count_d = count_q + LIMIT_W'(1);
          end
          if (abort_now || reading > thresh_q) begin
            phase_d    = PH_REFINE;
            best_rd_d  = reading;
            best_pos_d = '0;
            round_d    = '0;
            minus_d    = 1'b0;
            move_d     = MOVE_W'(round_offset('0));
            cur_d      = round_offset('0);
          end
        end
        PH_REFINE: begin
          has_res    = 1'b1;
          use_target = 1'b1;
          if (reading > best_rd_q) begin
            best_rd_d = reading;
            best_new  = cur_q;
          end
          best_pos_d = best_new;
          if (!minus_q) begin
            minus_d = 1'b1;
            target  = best_new - round_offset(round_q);
          end else begin
            round_d = round_nx;
            minus_d = 1'b0;
            if (round_live(round_nx)) begin
              target = best_new + round_offset(round_nx);
            end else begin
              phase_d = PH_IDLE;
              target  = best_new;
              cal_d   = 1'b1;
            end
          end
        end
        default: begin
          has_res = 1'b0;
        end
      endcase
    end

    if (use_target) begin
      move_d = MOVE_W'(target - cur_q);
      cur_d  = target;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_W'(32);
      limit_q  <= LIMIT_W'(360);
      step_q   <= STEP_W'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: thresh_q <= cfg_wdata_i[THRESH_W-1:0];
        CFG_LIMIT:     limit_q  <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_STEP:      step_q   <= cfg_wdata_i[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      cur_q       <= '0;
      best_pos_q  <= '0;
      best_rd_q   <= '0;
      round_q     <= '0;
      minus_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_move_q  <= '0;
      out_cal_q   <= 1'b0;
    end else if (s_acc) begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      best_pos_q  <= best_pos_d;
      best_rd_q   <= best_rd_d;
      round_q     <= round_d;
      minus_q     <= minus_d;
      out_valid_q <= has_res;
      if (has_res) begin
        out_move_q <= move_d;
        out_cal_q  <= cal_d;
      end
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_idle_reading_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && op == OP_READING && phase_q == PH_IDLE |=> phase_q == PH_IDLE && !out_valid_q)
    else $error("reading while idle changed state or made a word");

  a_start_enters_coarse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && op == OP_START |=> phase_q == PH_COARSE && count_q == '0 && out_valid_q
      && !out_cal_q)
    else $error("start word did not begin a coarse search");

  a_cal_only_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_cal_q |-> phase_q == PH_IDLE)
    else $error("calibrated move shown while search still runs");

  a_refine_round_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_REFINE |-> round_live(round_q))
    else $error("refinement running past its last round");
`endif

endmodule
